FILE: hw/rtl/sring_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and ring arithmetic for the serial ring buffer block.
package sring_pkg;

  localparam int RING_DEPTH = 256;
  localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [1:0] {
    MODE_PUT      = 2'd0,
    MODE_GET      = 2'd1,
    MODE_TX_READY = 2'd2,
    MODE_RX_BYTE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TX_FULL  = 3'd1,
    ST_RX_EMPTY = 3'd2,
    ST_TX_EMPTY = 3'd3,
    ST_RX_FULL  = 3'd4
  } status_t;

  typedef logic [PTR_W-1:0] ptr_t;

  // Occupancy flags of one ring.
  typedef struct packed {
    logic full;
    logic empty;
  } ring_stat_t;

  // Advance a ring pointer, wrapping at the last slot.
  function automatic ptr_t ptr_next(input ptr_t p);
    ptr_t r;
    if (p == PTR_W'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/sring_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one registered read port.
module sring_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/sring_ring.sv
`timescale 1ns / 1ps
// One circular byte ring: write and read pointers around a byte RAM.
module sring_ring
  import sring_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] push_data,
  input  logic       pop,
  output ring_stat_t stat,
  output logic [7:0] pop_data
);

  ptr_t wr_ptr;
  ptr_t rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_next(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_next(rd_ptr);
      end
    end
  end

  // One slot stays unused so full and empty differ.
  assign stat.empty = (wr_ptr == rd_ptr);
  assign stat.full  = (ptr_next(wr_ptr) == rd_ptr);

  sring_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH (8),
    .AW    (PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (wr_ptr),
    .wdata (push_data),
    .re    (pop),
    .raddr (rd_ptr),
    .rdata (pop_data)
  );

endmodule

FILE: hw/rtl/serial_tx_rx_ring_buffers_core.sv
`timescale 1ns / 1ps
// Top level: transmit and receive byte rings for a serial port, with echo.
//
// A request is taken at a rising edge with start high and busy low; its results
// appear on the result ports one per cycle, each marked by result_valid for a
// single cycle, and the receiver must take them as they come. A host put, a
// failed get, an empty transmitter-ready event and a received byte without the
// carriage-return echo give one result in the cycle after the request, so the
// block can take a new request every cycle. A host get or transmitter-ready
// event that finds data reads the ring RAM through its registered read port:
// busy is high in the read state, and the result passes the RAM read register
// and the output register. A received carriage return with echo on gives
// three results on consecutive cycles (CR, CR, LF) and holds busy in S_ECHO1
// and S_ECHO2. Each ring holds RING_DEPTH - 1 bytes. The echo_enable register
// may be written at any edge with echo_enable_we; it resets to 1.
module serial_tx_rx_ring_buffers_core
  import sring_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // request channel
  input  logic       start,
  output logic       busy,
  input  logic [1:0] mode,
  input  logic [7:0] data_byte,
  // configuration
  input  logic       echo_enable_we,
  input  logic       echo_enable_wdata,
  // result channel
  output logic       result_valid,
  output logic       line_valid,
  output logic [7:0] line_byte,
  output logic       host_valid,
  output logic [7:0] host_byte,
  output logic [2:0] status,
  output logic       tx_irq_enable,
  output logic       rx_irq_enable,
  output logic       last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_ECHO1,
    S_ECHO2
  } state_t;

  state_t     state;
  logic       echo_enable;
  logic       tx_irq;
  logic       rx_irq;
  logic       pend_host;    // pending ring read is for the host, else for the line

  ring_stat_t tx_stat;
  ring_stat_t rx_stat;
  logic [7:0] tx_rd_data;
  logic [7:0] rx_rd_data;

  logic       accept;
  logic       tx_push;
  logic       tx_pop;
  logic       rx_push;
  logic       rx_pop;
  logic [7:0] rx_store_byte;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Ring accesses are decided at the request edge from the current pointers.
  assign tx_push = accept && (mode == MODE_PUT)      && !tx_stat.full;
  assign tx_pop  = accept && (mode == MODE_TX_READY) && !tx_stat.empty;
  assign rx_pop  = accept && (mode == MODE_GET)      && !rx_stat.empty;
  assign rx_push = accept && (mode == MODE_RX_BYTE)  && !rx_stat.full;

  // Store received carriage returns as newlines.
  assign rx_store_byte = (data_byte == CH_CR) ? CH_LF : data_byte;

  // Flags only change on a request, so every result of it sees the new value.
  assign tx_irq_enable = tx_irq;
  assign rx_irq_enable = rx_irq;

  sring_ring u_tx_ring (
    .clk       (clk),
    .rst       (rst),
    .push      (tx_push),
    .push_data (data_byte),
    .pop       (tx_pop),
    .stat      (tx_stat),
    .pop_data  (tx_rd_data)
  );

  sring_ring u_rx_ring (
    .clk       (clk),
    .rst       (rst),
    .push      (rx_push),
    .push_data (rx_store_byte),
    .pop       (rx_pop),
    .stat      (rx_stat),
    .pop_data  (rx_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      echo_enable  <= 1'b1;
      tx_irq       <= 1'b0;
      rx_irq       <= 1'b0;
      pend_host    <= 1'b0;
      result_valid <= 1'b0;
      line_valid   <= 1'b0;
      host_valid   <= 1'b0;
      last         <= 1'b0;
    end else begin
      if (echo_enable_we) begin
        echo_enable <= echo_enable_wdata;
      end

      // Drop the previous result; fields go back to their idle values.
      result_valid <= 1'b0;
      line_valid   <= 1'b0;
      line_byte    <= '0;
      host_valid   <= 1'b0;
      host_byte    <= '0;
      status       <= ST_OK;
      last         <= 1'b1;

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (mode)
              MODE_PUT: begin
                tx_irq       <= 1'b1;
                result_valid <= 1'b1;
                status       <= tx_stat.full ? ST_TX_FULL : ST_OK;
              end
              MODE_GET: begin
                rx_irq <= 1'b1;
                if (rx_stat.empty) begin
                  result_valid <= 1'b1;
                  status       <= ST_RX_EMPTY;
                end else begin
                  pend_host <= 1'b1;
                  state     <= S_READ;
                end
              end
              MODE_TX_READY: begin
                if (tx_stat.empty) begin
                  tx_irq       <= 1'b0;
                  result_valid <= 1'b1;
                  status       <= ST_TX_EMPTY;
                end else begin
                  tx_irq    <= 1'b1;
                  pend_host <= 1'b0;
                  state     <= S_READ;
                end
              end
              MODE_RX_BYTE: begin
                result_valid <= 1'b1;
                if (rx_stat.full) begin
                  rx_irq <= 1'b0;
                  status <= ST_RX_FULL;
                end else begin
                  rx_irq <= 1'b1;
                  if (echo_enable) begin
                    line_valid <= 1'b1;
                    line_byte  <= data_byte;
                    if (data_byte == CH_CR) begin
                      // Raw CR first, then CR LF from the states S_ECHO1 and S_ECHO2.
                      last  <= 1'b0;
                      state <= S_ECHO1;
                    end
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          // RAM data for the popped slot is valid this cycle.
          result_valid <= 1'b1;
          if (pend_host) begin
            host_valid <= 1'b1;
            host_byte  <= rx_rd_data;
          end else begin
            line_valid <= 1'b1;
            line_byte  <= tx_rd_data;
          end
          state <= S_IDLE;
        end
        S_ECHO1: begin
          result_valid <= 1'b1;
          line_valid   <= 1'b1;
          line_byte    <= CH_CR;
          last         <= 1'b0;
          state        <= S_ECHO2;
        end
        S_ECHO2: begin
          result_valid <= 1'b1;
          line_valid   <= 1'b1;
          line_byte    <= CH_LF;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result that is not the final one is always followed by another.
  a_chain_continues: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> result_valid)
    else $error("echo sequence broken before its final result");

  // More results still to come keep new requests out.
  a_chain_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> busy)
    else $error("request window open inside an echo sequence");

  // A dropped received byte is never echoed and clears the receive flag.
  a_rx_full_drop: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_RX_FULL) |-> !line_valid && !rx_irq_enable)
    else $error("rx full result echoed or left rx flag set");

  // A ring read request always waits in S_READ for the RAM data.
  a_read_wait: assert property (@(posedge clk) disable iff (rst)
    tx_pop || rx_pop |=> busy && !result_valid ##1 result_valid && last)
    else $error("ring read result not delivered after RAM latency");

  // One ring access per request: never a push and a pop together.
  a_single_access: assert property (@(posedge clk) disable iff (rst)
    $countones({tx_push, tx_pop, rx_push, rx_pop}) <= 1)
    else $error("more than one ring access in a cycle");

endmodule
